// ===== rtl/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, register indexes, micro-operation codes, the control-store
// program and the control and status bundles between sequencer and datapath.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int DATA_W    = 32;
    localparam int LIMIT_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 5;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_INTEG_LIM  = 3'd3,
        REG_DRIVE_MIN  = 3'd4,
        REG_DRIVE_MAX  = 3'd5,
        REG_SETPOINT   = 3'd6,
        REG_SETTLE_TOL = 3'd7
    } cfg_reg_t;

    // Datapath micro-operations.
    typedef enum logic [4:0] {
        OP_NOP         = 5'd0,
        OP_ERR         = 5'd1,
        OP_DIFF        = 5'd2,
        OP_DIV_START   = 5'd3,
        OP_MUL_P       = 5'd4,
        OP_SAVE_P      = 5'd5,
        OP_MUL_EDT     = 5'd6,
        OP_INTEG_ADD   = 5'd7,
        OP_INTEG_CLAMP = 5'd8,
        OP_MUL_I       = 5'd9,
        OP_SUM_PI      = 5'd10,
        OP_MUL_D       = 5'd11,
        OP_SUM_D       = 5'd12,
        OP_CLAMP_MAX   = 5'd13,
        OP_CLAMP_MIN   = 5'd14,
        OP_COMMIT      = 5'd15,
        OP_CLEAR       = 5'd16,
        OP_HOLD        = 5'd17
    } op_t;

    // Jump conditions of a control word.
    typedef enum logic [1:0] {
        JMP_NONE     = 2'd0,
        JMP_CLEAR    = 2'd1,
        JMP_HOLD     = 2'd2,
        JMP_DIV_BUSY = 2'd3
    } jump_t;

    typedef struct packed {
        op_t               op;
        jump_t             jump;
        logic [STEP_W-1:0] target;
        logic              last;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic load;
    } dp_ctrl_t;

    typedef struct packed {
        logic is_clear;
        logic is_hold;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // Program entry points that are jump targets.
    localparam logic [STEP_W-1:0] STEP_WAIT_DIV = 5'd12;
    localparam logic [STEP_W-1:0] STEP_CLEAR    = 5'd18;
    localparam logic [STEP_W-1:0] STEP_HOLD     = 5'd19;
    localparam logic [STEP_W-1:0] STEP_NONE     = 5'd0;

    function automatic uword_t uw(input op_t op, input jump_t jump,
                                  input logic [STEP_W-1:0] target, input logic last);
        uword_t w;
        w.op     = op;
        w.jump   = jump;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    // Control store: one control word per step.
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
        uword_t w;
        case (addr)
            5'd0:    w = uw(OP_NOP,         JMP_CLEAR,    STEP_CLEAR,    1'b0);
            5'd1:    w = uw(OP_NOP,         JMP_HOLD,     STEP_HOLD,     1'b0);
            5'd2:    w = uw(OP_ERR,         JMP_NONE,     STEP_NONE,     1'b0);
            5'd3:    w = uw(OP_DIFF,        JMP_NONE,     STEP_NONE,     1'b0);
            5'd4:    w = uw(OP_DIV_START,   JMP_NONE,     STEP_NONE,     1'b0);
            5'd5:    w = uw(OP_MUL_P,       JMP_NONE,     STEP_NONE,     1'b0);
            5'd6:    w = uw(OP_SAVE_P,      JMP_NONE,     STEP_NONE,     1'b0);
            5'd7:    w = uw(OP_MUL_EDT,     JMP_NONE,     STEP_NONE,     1'b0);
            5'd8:    w = uw(OP_INTEG_ADD,   JMP_NONE,     STEP_NONE,     1'b0);
            5'd9:    w = uw(OP_INTEG_CLAMP, JMP_NONE,     STEP_NONE,     1'b0);
            5'd10:   w = uw(OP_MUL_I,       JMP_NONE,     STEP_NONE,     1'b0);
            5'd11:   w = uw(OP_SUM_PI,      JMP_NONE,     STEP_NONE,     1'b0);
            5'd12:   w = uw(OP_NOP,         JMP_DIV_BUSY, STEP_WAIT_DIV, 1'b0);
            5'd13:   w = uw(OP_MUL_D,       JMP_NONE,     STEP_NONE,     1'b0);
            5'd14:   w = uw(OP_SUM_D,       JMP_NONE,     STEP_NONE,     1'b0);
            5'd15:   w = uw(OP_CLAMP_MAX,   JMP_NONE,     STEP_NONE,     1'b0);
            5'd16:   w = uw(OP_CLAMP_MIN,   JMP_NONE,     STEP_NONE,     1'b0);
            5'd17:   w = uw(OP_COMMIT,      JMP_NONE,     STEP_NONE,     1'b1);
            5'd18:   w = uw(OP_CLEAR,       JMP_NONE,     STEP_NONE,     1'b1);
            5'd19:   w = uw(OP_HOLD,        JMP_NONE,     STEP_NONE,     1'b1);
            default: w = uw(OP_NOP,         JMP_NONE,     STEP_NONE,     1'b1);
        endcase
        return w;
    endfunction

    // Saturate a 33-bit signed sum or difference to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? S32_MIN : S32_MAX;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/pidaw_divider.sv =====
// ----------------------------------------------------------------------------
// PID derivative divider
// Radix-2 restoring divider, two quotient bits per cycle, that forms
// sat32((diff << FRAC_BITS) / divisor) with truncation toward zero.
// ----------------------------------------------------------------------------
module pidaw_divider
    import pidaw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] dividend,
    input  logic        [DATA_W-1:0] divisor,
    output logic                     busy,
    output logic signed [DATA_W-1:0] quotient
);

    localparam int DVD_W = DATA_W + FRAC_BITS;
    localparam int PAIRS = (DVD_W + 1) / 2;
    localparam int QW    = 2 * PAIRS;
    localparam int CNT_W = $clog2(PAIRS + 1);

    logic [DATA_W:0]          rem_reg, rem_next;
    logic [QW-1:0]            quo_reg, quo_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     run_reg, fix_reg, neg_reg;
    logic [DATA_W-1:0]        divisor_reg;
    logic signed [DATA_W-1:0] quot_reg, quot_sat;
    logic [DATA_W-1:0]        mag;
    logic                     over;

    // Magnitude of the signed dividend; the most negative value maps to 2^31.
    assign mag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;

    // Two restoring steps per cycle.
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < 2; k++) begin
            rem_next = {rem_next[DATA_W-1:0], quo_next[QW-1]};
            quo_next = {quo_next[QW-2:0], 1'b0};
            if (rem_next >= {1'b0, divisor_reg}) begin
                rem_next    = rem_next - {1'b0, divisor_reg};
                quo_next[0] = 1'b1;
            end
        end
    end

    // Apply the sign and saturate the quotient magnitude to 32 bits.
    always_comb begin
        if (neg_reg) begin
            over     = (|quo_reg[QW-1:DATA_W]) ||
                       (quo_reg[DATA_W-1] && (|quo_reg[DATA_W-2:0]));
            quot_sat = over ? S32_MIN : -$signed(quo_reg[DATA_W-1:0]);
        end else begin
            over     = (|quo_reg[QW-1:DATA_W]) || quo_reg[DATA_W-1];
            quot_sat = over ? S32_MAX : $signed(quo_reg[DATA_W-1:0]);
        end
    end

    // Control of the iteration count and the final sign step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            fix_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            run_reg <= 1'b1;
            fix_reg <= 1'b0;
            cnt_reg <= CNT_W'(PAIRS);
        end else if (run_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                run_reg <= 1'b0;
                fix_reg <= 1'b1;
            end
        end else begin
            fix_reg <= 1'b0;
        end
    end

    // Working registers of the division.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg     <= '0;
            quo_reg     <= QW'(mag) << FRAC_BITS;
            neg_reg     <= dividend[DATA_W-1];
            divisor_reg <= divisor;
        end else if (run_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (fix_reg) begin
            quot_reg <= quot_sat;
        end
    end

    assign busy     = run_reg | fix_reg;
    assign quotient = quot_reg;

endmodule

// ===== rtl/pidaw_datapath.sv =====
// ----------------------------------------------------------------------------
// PID datapath
// Configuration registers, controller state, working registers, one
// registered multiplier, the divider and the result register, all driven by
// one micro-operation per cycle.
// ----------------------------------------------------------------------------
module pidaw_datapath
    import pidaw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_ctrl_t                 ctrl,
    output dp_status_t               status,
    input  logic                     s_cmd,
    input  logic signed [DATA_W-1:0] s_measurement,
    input  logic        [DATA_W-1:0] s_time_step,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic        [DATA_W-1:0] cfg_data,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic signed [DATA_W-1:0] m_drive,
    output logic                     m_at_setpoint,
    output logic                     m_held
);

    localparam int OPND_W = DATA_W + 1;
    localparam int PROD_W = 2 * OPND_W;

    // Configuration registers.
    logic signed [DATA_W-1:0]  prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic        [LIMIT_W-1:0] integ_limit_reg, settle_tol_reg;
    logic signed [DATA_W-1:0]  drive_min_reg, drive_max_reg, setpoint_reg;

    // Controller state.
    logic signed [DATA_W-1:0] last_error_reg, last_error_next;
    logic signed [DATA_W-1:0] integ_acc_reg, integ_acc_next;
    logic signed [DATA_W-1:0] last_drive_reg, last_drive_next;

    // Item and working registers.
    logic                     cmd_reg;
    logic signed [DATA_W-1:0] meas_reg;
    logic        [DATA_W-1:0] dt_reg;
    logic signed [DATA_W-1:0] err_reg, err_next;
    logic signed [DATA_W-1:0] diff_reg, diff_next;
    logic signed [DATA_W-1:0] p_reg, p_next;
    logic signed [DATA_W-1:0] integ_reg, integ_next;
    logic signed [DATA_W-1:0] drv_reg, drv_next;
    logic signed [PROD_W-1:0] prod_reg;

    // Result register.
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_drive_reg, m_drive_next;
    logic                     m_at_reg, m_at_next;
    logic                     m_held_reg, m_held_next;

    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic                     mul_en;
    logic signed [DATA_W-1:0] prod_fx;
    logic signed [DATA_W-1:0] lim_pos, lim_neg;
    logic                     div_busy;
    logic signed [DATA_W-1:0] div_quot;
    logic                     out_free;

    // Product shifted down by the fraction width (floor) and saturated.
    function automatic logic signed [DATA_W-1:0] fx_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        logic signed [DATA_W-1:0] r;
        s = p >>> FRAC_BITS;
        if ((&s[PROD_W-1:DATA_W-1]) || !(|s[PROD_W-1:DATA_W-1])) begin
            r = s[DATA_W-1:0];
        end else begin
            r = s[PROD_W-1] ? S32_MIN : S32_MAX;
        end
        return r;
    endfunction

    // True when the error magnitude is within the tolerance.
    function automatic logic within_tol(input logic signed [DATA_W-1:0] v,
                                        input logic [LIMIT_W-1:0] tol);
        logic signed [DATA_W:0] ext;
        logic        [DATA_W:0] mag;
        ext = {v[DATA_W-1], v};
        mag = ext[DATA_W] ? -ext : ext;
        return mag <= {2'b00, tol};
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign prod_fx  = fx_sat(prod_reg);
    assign lim_pos  = {1'b0, integ_limit_reg};
    assign lim_neg  = -lim_pos;

    pidaw_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.op == OP_DIV_START),
        .dividend (diff_reg),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Multiplier operand selection.
    always_comb begin
        mul_en = 1'b1;
        case (ctrl.op)
            OP_MUL_P: begin
                mul_a = {prop_gain_reg[DATA_W-1], prop_gain_reg};
                mul_b = {err_reg[DATA_W-1], err_reg};
            end
            OP_MUL_EDT: begin
                mul_a = {err_reg[DATA_W-1], err_reg};
                mul_b = {1'b0, dt_reg};
            end
            OP_MUL_I: begin
                mul_a = {integ_gain_reg[DATA_W-1], integ_gain_reg};
                mul_b = {integ_reg[DATA_W-1], integ_reg};
            end
            OP_MUL_D: begin
                mul_a = {deriv_gain_reg[DATA_W-1], deriv_gain_reg};
                mul_b = {div_quot[DATA_W-1], div_quot};
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    // Micro-operation decode for working, state and result registers.
    always_comb begin
        err_next        = err_reg;
        diff_next       = diff_reg;
        p_next          = p_reg;
        integ_next      = integ_reg;
        drv_next        = drv_reg;
        last_error_next = last_error_reg;
        integ_acc_next  = integ_acc_reg;
        last_drive_next = last_drive_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_drive_next    = m_drive_reg;
        m_at_next       = m_at_reg;
        m_held_next     = m_held_reg;
        case (ctrl.op)
            OP_ERR: begin
                err_next = sat33({setpoint_reg[DATA_W-1], setpoint_reg} -
                                 {meas_reg[DATA_W-1], meas_reg});
            end
            OP_DIFF: begin
                diff_next = sat33({err_reg[DATA_W-1], err_reg} -
                                  {last_error_reg[DATA_W-1], last_error_reg});
            end
            OP_SAVE_P: begin
                p_next = prod_fx;
            end
            OP_INTEG_ADD: begin
                integ_next = sat33({integ_acc_reg[DATA_W-1], integ_acc_reg} +
                                   {prod_fx[DATA_W-1], prod_fx});
            end
            OP_INTEG_CLAMP: begin
                if (integ_reg > lim_pos) begin
                    integ_next = lim_pos;
                end else if (integ_reg < lim_neg) begin
                    integ_next = lim_neg;
                end
            end
            OP_SUM_PI: begin
                p_next = sat33({p_reg[DATA_W-1], p_reg} + {prod_fx[DATA_W-1], prod_fx});
            end
            OP_SUM_D: begin
                drv_next = sat33({p_reg[DATA_W-1], p_reg} + {prod_fx[DATA_W-1], prod_fx});
            end
            OP_CLAMP_MAX: begin
                if (drv_reg > drive_max_reg) begin
                    drv_next = drive_max_reg;
                end
            end
            OP_CLAMP_MIN: begin
                if (drv_reg < drive_min_reg) begin
                    drv_next = drive_min_reg;
                end
            end
            OP_COMMIT: begin
                integ_acc_next  = integ_reg;
                last_error_next = err_reg;
                last_drive_next = drv_reg;
                m_valid_next    = 1'b1;
                m_drive_next    = drv_reg;
                m_at_next       = within_tol(err_reg, settle_tol_reg);
                m_held_next     = 1'b0;
            end
            OP_CLEAR: begin
                integ_acc_next  = '0;
                last_error_next = '0;
                last_drive_next = '0;
                m_valid_next    = 1'b1;
                m_drive_next    = '0;
                m_at_next       = 1'b1;
                m_held_next     = 1'b0;
            end
            OP_HOLD: begin
                m_valid_next = 1'b1;
                m_drive_next = last_drive_reg;
                m_at_next    = within_tol(last_error_reg, settle_tol_reg);
                m_held_next  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            integ_limit_reg <= '0;
            drive_min_reg   <= S32_MIN;
            drive_max_reg   <= S32_MAX;
            setpoint_reg    <= '0;
            settle_tol_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:  prop_gain_reg   <= cfg_data;
                REG_INTEG_GAIN: integ_gain_reg  <= cfg_data;
                REG_DERIV_GAIN: deriv_gain_reg  <= cfg_data;
                REG_INTEG_LIM:  integ_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_DRIVE_MIN:  drive_min_reg   <= cfg_data;
                REG_DRIVE_MAX:  drive_max_reg   <= cfg_data;
                REG_SETPOINT:   setpoint_reg    <= cfg_data;
                REG_SETTLE_TOL: settle_tol_reg  <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state and result handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= '0;
            integ_acc_reg  <= '0;
            last_drive_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            last_error_reg <= last_error_next;
            integ_acc_reg  <= integ_acc_next;
            last_drive_reg <= last_drive_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Item capture, working registers, product and result payload.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg  <= s_cmd;
            meas_reg <= s_measurement;
            dt_reg   <= s_time_step;
        end
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        err_reg     <= err_next;
        diff_reg    <= diff_next;
        p_reg       <= p_next;
        integ_reg   <= integ_next;
        drv_reg     <= drv_next;
        m_drive_reg <= m_drive_next;
        m_at_reg    <= m_at_next;
        m_held_reg  <= m_held_next;
    end

    assign status.is_clear = cmd_reg;
    assign status.is_hold  = (dt_reg == '0);
    assign status.div_busy = div_busy;
    assign status.out_free = out_free;

    assign m_valid       = m_valid_reg;
    assign m_drive       = m_drive_reg;
    assign m_at_setpoint = m_at_reg;
    assign m_held        = m_held_reg;

endmodule

// ===== rtl/pidaw_sequencer.sv =====
// ----------------------------------------------------------------------------
// PID microcode sequencer
// Step counter over the control store with conditional jumps; issues one
// micro-operation per cycle and holds on the final step until the result
// register is free.
// ----------------------------------------------------------------------------
module pidaw_sequencer
    import pidaw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_ctrl_t   ctrl
);

    logic              run_reg, run_next;
    logic [STEP_W-1:0] step_reg, step_next;
    uword_t            word;
    logic              take;
    logic              stall;
    logic              jump_taken;

    assign word    = ucode_rom(step_reg);
    assign s_ready = !run_reg;
    assign take    = s_valid && s_ready;
    assign stall   = word.last && !status.out_free;

    // Jump condition of the current control word.
    always_comb begin
        case (word.jump)
            JMP_CLEAR:    jump_taken = status.is_clear;
            JMP_HOLD:     jump_taken = status.is_hold;
            JMP_DIV_BUSY: jump_taken = status.div_busy;
            default:      jump_taken = 1'b0;
        endcase
    end

    // Next step and run flag.
    always_comb begin
        run_next  = run_reg;
        step_next = step_reg;
        if (take) begin
            run_next  = 1'b1;
            step_next = '0;
        end else if (run_reg && !stall) begin
            if (word.last) begin
                run_next = 1'b0;
            end else if (jump_taken) begin
                step_next = word.target;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end else begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

    assign ctrl.op   = (run_reg && !stall) ? word.op : OP_NOP;
    assign ctrl.load = take;

endmodule

// ===== rtl/pid_controller_antiwindup.sv =====
// ----------------------------------------------------------------------------
// PID controller with integral clamp
// Fixed-point PID loop with anti-windup, output limits, hold on zero time
// step and a clear command, run by a microcoded sequencer.
//
//   Channel  | Direction | Handshake           | Payload
//   ---------+-----------+---------------------+-------------------------------
//   s_       | in        | s_valid / s_ready   | s_cmd, s_measurement, s_time_step
//   m_       | out       | m_valid / m_ready   | m_drive, m_at_setpoint, m_held
//   cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An update waits for the two-bit-per-cycle divider to finish; a hold or a
// clear skips the division.
// One item is in work at a time; s_ready is high while the sequencer is idle.
// A result waiting in the output register stalls only the final step.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup
    import pidaw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic signed [DATA_W-1:0] s_measurement,
    input  logic        [DATA_W-1:0] s_time_step,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_drive,
    output logic                     m_at_setpoint,
    output logic                     m_held,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic        [DATA_W-1:0] cfg_data
);

    dp_ctrl_t   ctrl;
    dp_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    pidaw_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    pidaw_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .status        (status),
        .s_cmd         (s_cmd),
        .s_measurement (s_measurement),
        .s_time_step   (s_time_step),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_drive       (m_drive),
        .m_at_setpoint (m_at_setpoint),
        .m_held        (m_held)
    );

    // The divider is never left running when a new item arrives.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !status.div_busy)
        else $error("divider busy at input transfer");

    // A transfer starts the program, which closes the input in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after transfer");

    // A new result appears only at the end of an item in work.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without an item in work");

endmodule

// ===== tb/pid_controller_antiwindup_chk.sv =====
// ----------------------------------------------------------------------------
// PID controller checker
// Watches the configuration, sample and result channels of the PID controller.
// It keeps its own copy of the registers and of the loop state, predicts the
// result of every accepted sample, and compares each result transfer field by
// field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_chk import pidaw_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_cmd,
    input  logic signed [DATA_W-1:0] s_measurement,
    input  logic        [DATA_W-1:0] s_time_step,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [DATA_W-1:0] m_drive,
    input  logic                     m_at_setpoint,
    input  logic                     m_held,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic        [DATA_W-1:0] cfg_data,
    output int                       mismatches,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic                     at_setpoint;
        logic                     held;
    } loop_result_t;

    // Register copies, widened so that all arithmetic happens in 64 bits.
    longint kp, ki, kd, integ_bound, out_lo, out_hi, target, tol;

    // Loop state.
    longint prev_err, integ_sum, prev_drive;

    // Predicted results, oldest first.
    loop_result_t predicted_q[$];

    function automatic longint clip_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // Fixed-point product: full product, shift that rounds toward minus
    // infinity, then saturation to one word.
    function automatic longint q_mul(input longint a, input longint b);
        return clip_word((a * b) >>> FRAC_BITS);
    endfunction

    // One step of the loop: clear, hold on a zero time step, or a full update.
    function automatic loop_result_t pid_update(input logic cmd, input longint meas,
                                                input longint dt);
        loop_result_t r;
        longint err, p, integ, i, diff, deriv, d, drv;
        r.held = 1'b0;
        if (cmd) begin
            prev_err   = 0;
            integ_sum  = 0;
            prev_drive = 0;
            drv        = 0;
        end else if (dt == 0) begin
            drv    = prev_drive;
            r.held = 1'b1;
        end else begin
            err   = clip_word(target - meas);
            p     = q_mul(kp, err);
            integ = clip_word(integ_sum + q_mul(err, dt));
            if (integ > integ_bound) integ = integ_bound;
            if (integ < -integ_bound) integ = -integ_bound;
            i     = q_mul(ki, integ);
            diff  = clip_word(err - prev_err);
            // Division truncates toward zero.
            deriv = clip_word((diff * (64'sd1 <<< FRAC_BITS)) / dt);
            d     = q_mul(kd, deriv);
            drv   = clip_word(clip_word(p + i) + d);
            // The upper limit applies first, so the lower one wins when inverted.
            if (drv > out_hi) drv = out_hi;
            if (drv < out_lo) drv = out_lo;
            integ_sum  = integ;
            prev_err   = err;
            prev_drive = drv;
        end
        r.drive       = drv[DATA_W-1:0];
        r.at_setpoint = (((prev_err < 0) ? -prev_err : prev_err) <= tol);
        return r;
    endfunction

    // Track register writes, compare results and predict samples, in that order.
    always @(posedge aclk) begin : watch
        loop_result_t want;
        int bad;
        bad = 0;
        if (!aresetn) begin
            kp          = 0;
            ki          = 0;
            kd          = 0;
            integ_bound = 0;
            out_lo      = WORD_MIN;
            out_hi      = WORD_MAX;
            target      = 0;
            tol         = 0;
            prev_err    = 0;
            integ_sum   = 0;
            prev_drive  = 0;
            predicted_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_PROP_GAIN:  kp          = longint'($signed(cfg_data));
                    REG_INTEG_GAIN: ki          = longint'($signed(cfg_data));
                    REG_DERIV_GAIN: kd          = longint'($signed(cfg_data));
                    REG_INTEG_LIM:  integ_bound = longint'(cfg_data[LIMIT_W-1:0]);
                    REG_DRIVE_MIN:  out_lo      = longint'($signed(cfg_data));
                    REG_DRIVE_MAX:  out_hi      = longint'($signed(cfg_data));
                    REG_SETPOINT:   target      = longint'($signed(cfg_data));
                    REG_SETTLE_TOL: tol         = longint'(cfg_data[LIMIT_W-1:0]);
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (predicted_q.size() == 0) begin
                    $error("result transfer with no prediction waiting: drive %0d", m_drive);
                    bad++;
                end else begin
                    want = predicted_q.pop_front();
                    if (m_drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d", want.drive, m_drive);
                        bad++;
                    end
                    if (m_at_setpoint !== want.at_setpoint) begin
                        $error("at_setpoint: expected %0b, actual %0b",
                               want.at_setpoint, m_at_setpoint);
                        bad++;
                    end
                    if (m_held !== want.held) begin
                        $error("held: expected %0b, actual %0b", want.held, m_held);
                        bad++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                predicted_q.push_back(pid_update(s_cmd, longint'(s_measurement),
                                                 longint'(s_time_step)));
            end

            mismatches  <= mismatches + bad;
            outstanding <= predicted_q.size();
        end
    end

endmodule

// ===== tb/pid_controller_antiwindup_tb.sv =====
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives register settings and samples into the PID controller and accepts
// its results under changing idle patterns on both sides, including a long
// stall of the result side. A checker beside the block predicts and compares
// every result; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_tb import pidaw_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = 16;
    localparam int QUIET_LIMIT  = 5000;
    localparam int LONG_HOLDOFF = 400;
    localparam int TAIL_CYCLES  = 80;
    localparam int CHUNKS       = 6;
    localparam int CHUNK_ITEMS  = 88;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_cmd         = 1'b0;
    logic signed [DATA_W-1:0] s_measurement = '0;
    logic        [DATA_W-1:0] s_time_step   = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic signed [DATA_W-1:0] m_drive;
    logic                     m_at_setpoint;
    logic                     m_held;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index     = '0;
    logic        [DATA_W-1:0] cfg_data      = '0;

    int mismatches;
    int outstanding;

    // Register image that the next load writes.
    logic [DATA_W-1:0] reg_img [8];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit holdoff_go    = 1'b0;

    pid_controller_antiwindup #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_measurement(s_measurement),
        .s_time_step  (s_time_step),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive      (m_drive),
        .m_at_setpoint(m_at_setpoint),
        .m_held       (m_held),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pid_controller_antiwindup_chk #(
        .FRAC_BITS(FRAC_BITS)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_measurement(s_measurement),
        .s_time_step  (s_time_step),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive      (m_drive),
        .m_at_setpoint(m_at_setpoint),
        .m_held       (m_held),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: random back-pressure, plus one long stall on request.
    always begin : sink
        bit holdoff_done;
        @(posedge aclk);
        if (holdoff_go && !holdoff_done) begin
            holdoff_done = 1'b1;
            m_ready <= 1'b0;
            repeat (LONG_HOLDOFF) @(posedge aclk);
        end
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Ends the run when no transfer happens on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one sample and returns at the edge of its transfer, with valid
    // still high; a following offer either replaces the payload there or idles.
    task automatic offer(input logic cmd, input logic [DATA_W-1:0] meas,
                         input logic [DATA_W-1:0] dt);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_measurement <= meas;
        s_time_step   <= dt;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Writes the whole register image while the block is idle.
    task automatic load_regs();
        cfg_reg_t idx;
        drain();
        idx = idx.first();
        repeat (idx.num()) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= reg_img[idx];
            do @(posedge aclk); while (!cfg_ready);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct <= sink_pct;
    endtask

    // Mostly values within +/- span, now and then an extreme or a full word.
    function automatic logic [DATA_W-1:0] any_word(input int unsigned span);
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(2 * span) - span;
        endcase
    endfunction

    // Random settings; limits are usually ordered but sometimes inverted.
    task automatic pick_random_regs();
        logic [DATA_W-1:0] lo, hi, tmp;
        reg_img[REG_PROP_GAIN]  = any_word(32'h0002_0000);
        reg_img[REG_INTEG_GAIN] = any_word(32'h0001_0000);
        reg_img[REG_DERIV_GAIN] = any_word(32'h0000_8000);
        case ($urandom_range(5))
            0:       reg_img[REG_INTEG_LIM] = '0;
            1:       reg_img[REG_INTEG_LIM] = $urandom();
            default: reg_img[REG_INTEG_LIM] = $urandom_range(32'h0040_0000);
        endcase
        lo = any_word(32'h00C8_0000);
        hi = any_word(32'h00C8_0000);
        if ($urandom_range(5) != 0 && $signed(lo) > $signed(hi)) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        reg_img[REG_DRIVE_MIN] = lo;
        reg_img[REG_DRIVE_MAX] = hi;
        reg_img[REG_SETPOINT]  = any_word(32'h0032_0000);
        if ($urandom_range(4) == 0) begin
            reg_img[REG_SETTLE_TOL] = $urandom();
        end else begin
            reg_img[REG_SETTLE_TOL] = $urandom_range(32'h0002_0000);
        end
    endtask

    // Random samples: mostly updates near the setpoint, with clears, holds,
    // tiny and huge time steps and full-range measurements mixed in.
    task automatic run_samples(input int count, input int pause_at, input int holdoff_at);
        logic              cmd;
        logic [DATA_W-1:0] meas, dt;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) drain();
            if (k == holdoff_at) holdoff_go <= 1'b1;
            cmd = ($urandom_range(24) == 0);
            case ($urandom_range(19))
                0, 1:    dt = '0;
                2, 3:    dt = $urandom();
                4:       dt = $urandom_range(1, 16);
                default: dt = $urandom_range(32'h0000_0400, 32'h0002_0000);
            endcase
            if ($urandom_range(9) < 6) begin
                meas = reg_img[REG_SETPOINT] + $urandom_range(32'h0004_0000) - 32'h0002_0000;
            end else begin
                meas = any_word(32'h0064_0000);
            end
            offer(cmd, meas, dt);
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        set_idle(38, 49);

        // Clear and hold with the settings out of reset.
        offer(1'b1, $urandom(), $urandom());
        offer(1'b0, $urandom(), '0);

        // Moderate gains, setpoint 5.0, tolerance 0.5, drive within +/-100.
        reg_img[REG_PROP_GAIN]  = 32'h0001_0000;
        reg_img[REG_INTEG_GAIN] = 32'h0000_8000;
        reg_img[REG_DERIV_GAIN] = 32'h0000_4000;
        reg_img[REG_INTEG_LIM]  = 32'h000A_0000;
        reg_img[REG_DRIVE_MIN]  = 32'hFF9C_0000;
        reg_img[REG_DRIVE_MAX]  = 32'h0064_0000;
        reg_img[REG_SETPOINT]   = 32'h0005_0000;
        reg_img[REG_SETTLE_TOL] = 32'h0000_8000;
        load_regs();
        offer(1'b0, 32'h0005_0000, 32'h0001_0000);
        offer(1'b0, 32'h8000_0000, 32'h0001_0000);
        offer(1'b0, 32'h7FFF_FFFF, 32'h0001_0000);
        offer(1'b0, 32'h0004_0000, 32'h0000_0001);
        offer(1'b0, 32'h0006_0000, 32'hFFFF_FFFF);
        offer(1'b0, $urandom(), '0);
        // Error exactly at the tolerance, then one step beyond it.
        offer(1'b0, 32'h0005_8000, 32'h0001_0000);
        offer(1'b0, 32'h0004_7FFF, 32'h0001_0000);
        offer(1'b1, $urandom(), $urandom());
        offer(1'b0, $urandom(), '0);

        // Largest gains and bounds; the unsigned registers get bit 31 set too.
        reg_img[REG_PROP_GAIN]  = 32'h7FFF_FFFF;
        reg_img[REG_INTEG_GAIN] = 32'h7FFF_FFFF;
        reg_img[REG_DERIV_GAIN] = 32'h7FFF_FFFF;
        reg_img[REG_INTEG_LIM]  = 32'hFFFF_FFFF;
        reg_img[REG_DRIVE_MIN]  = 32'h8000_0000;
        reg_img[REG_DRIVE_MAX]  = 32'h7FFF_FFFF;
        reg_img[REG_SETPOINT]   = 32'h7FFF_FFFF;
        reg_img[REG_SETTLE_TOL] = 32'hFFFF_FFFF;
        load_regs();
        offer(1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
        offer(1'b0, 32'h7FFF_FFFF, 32'h0000_0001);
        offer(1'b0, 32'h0000_0000, 32'h8000_0000);
        offer(1'b0, $urandom(), '0);

        // Most negative gains, no integral room and inverted drive limits.
        reg_img[REG_PROP_GAIN]  = 32'h8000_0000;
        reg_img[REG_INTEG_GAIN] = 32'h8000_0000;
        reg_img[REG_DERIV_GAIN] = 32'h8000_0000;
        reg_img[REG_INTEG_LIM]  = 32'h0000_0000;
        reg_img[REG_DRIVE_MIN]  = 32'h0001_0000;
        reg_img[REG_DRIVE_MAX]  = 32'hFFFF_0000;
        reg_img[REG_SETPOINT]   = 32'h8000_0000;
        reg_img[REG_SETTLE_TOL] = 32'h0000_0000;
        load_regs();
        offer(1'b0, 32'h7FFF_FFFF, 32'h0001_0000);
        offer(1'b0, 32'h8000_0000, 32'h0000_0001);
        offer(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        offer(1'b1, $urandom(), $urandom());

        // Random settings per chunk; the idle pattern changes every two chunks.
        for (int c = 0; c < CHUNKS; c++) begin
            pick_random_regs();
            load_regs();
            case (c / 2)
                0:       set_idle(38, 49);
                1:       set_idle(49, 38);
                default: set_idle(0, 0);
            endcase
            run_samples(CHUNK_ITEMS, (c == 1) ? CHUNK_ITEMS / 2 : -1, (c == 4) ? 20 : -1);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
